FILE: design/gcs_pkg.sv
// shared types, codes and constants of the gamepad command state block
package gcs_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int AXIS_BITS       = 12;
  localparam int ACTION_BITS     = 2;
  localparam int BUTTON_BITS     = 3;
  localparam int TIMER_BITS      = 10;
  localparam int BAND_BITS       = 11;
  localparam int POWER_BITS      = 7;
  localparam int STEP_BITS       = 7;
  localparam int MODE_BITS       = 2;
  localparam int CFG_INDEX_BITS  = 4;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [POWER_BITS-1:0] POWER_MAX = POWER_BITS'(100);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  localparam logic [TIMER_BITS-1:0] COOL_TICKS_RST = TIMER_BITS'(250);
  localparam logic [BAND_BITS-1:0]  DEAD_BAND_RST  = BAND_BITS'(102);
  localparam logic [STEP_BITS-1:0]  FAST_STEP_RST  = STEP_BITS'(10);
  localparam logic [STEP_BITS-1:0]  SLOW_STEP_RST  = STEP_BITS'(1);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK   = 2'd0,
    ACT_BUTTON = 2'd1,
    ACT_UPDATE = 2'd2
  } action_e;

  typedef enum logic [BUTTON_BITS-1:0] {
    BTN_POWER_UP   = 3'd0,
    BTN_POWER_DOWN = 3'd1,
    BTN_FACE       = 3'd2,
    BTN_RELOAD     = 3'd3,
    BTN_MOVE_MODE  = 3'd4,
    BTN_SHOT_COUNT = 3'd5,
    BTN_FIRE       = 3'd6
  } button_e;

  typedef enum logic [MODE_BITS-1:0] {
    CMD_IDLE = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2,
    CMD_FIRE = 2'd3
  } shot_cmd_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_COOL_TICKS = 4'd0,
    CFG_DEAD_BAND  = 4'd1,
    CFG_FAST_STEP  = 4'd2,
    CFG_SLOW_STEP  = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TIMER_BITS-1:0] cool_ticks;
    logic [BAND_BITS-1:0]  dead_band;
    logic [STEP_BITS-1:0]  fast_step;
    logic [STEP_BITS-1:0]  slow_step;
  } cfg_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [BUTTON_BITS-1:0] button;
    logic                   fast_held;
    logic                   up_held;
    logic                   down_held;
    logic                   stop_level;
  } cmd_t;

  typedef struct packed {
    logic                  stop_flag;
    logic [MODE_BITS-1:0]  move_mode;
    logic [MODE_BITS-1:0]  face_mode;
    logic [MODE_BITS-1:0]  shot_command;
    logic [MODE_BITS-1:0]  shot_count;
    logic [POWER_BITS-1:0] power_level;
    logic                  reload_flag;
  } status_t;

endpackage

FILE: design/gcs_cmd_if.sv
// input channel: ticks, button edges and periodic updates
interface gcs_cmd_if #(
  parameter int SAMPLE_BITS = gcs_pkg::SAMPLE_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic [gcs_pkg::ACTION_BITS-1:0]    action;
  logic [gcs_pkg::BUTTON_BITS-1:0]    button;
  logic                               fast_held;
  logic                               up_held;
  logic                               down_held;
  logic                               stop_level;
  logic [SAMPLE_BITS-1:0]             stick_x;
  logic [SAMPLE_BITS-1:0]             stick_y;
  logic [SAMPLE_BITS-1:0]             stick_turn;

  modport source (
    output valid, action, button, fast_held, up_held, down_held, stop_level,
           stick_x, stick_y, stick_turn,
    input  ready
  );
  modport sink (
    input  valid, action, button, fast_held, up_held, down_held, stop_level,
           stick_x, stick_y, stick_turn,
    output ready
  );
endinterface

FILE: design/gcs_rpt_if.sv
// report channel: one transaction per periodic update
interface gcs_rpt_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   stop_flag;
  logic [gcs_pkg::MODE_BITS-1:0]          move_mode;
  logic [gcs_pkg::MODE_BITS-1:0]          face_mode;
  logic [gcs_pkg::MODE_BITS-1:0]          shot_command;
  logic [gcs_pkg::MODE_BITS-1:0]          shot_count;
  logic [gcs_pkg::POWER_BITS-1:0]         power_level;
  logic                                   reload_flag;
  logic signed [gcs_pkg::AXIS_BITS-1:0]   move_x;
  logic signed [gcs_pkg::AXIS_BITS-1:0]   move_y;
  logic signed [gcs_pkg::AXIS_BITS-1:0]   move_turn;

  modport source (
    output valid, stop_flag, move_mode, face_mode, shot_command, shot_count,
           power_level, reload_flag, move_x, move_y, move_turn,
    input  ready
  );
  modport sink (
    input  valid, stop_flag, move_mode, face_mode, shot_command, shot_count,
           power_level, reload_flag, move_x, move_y, move_turn,
    output ready
  );
endinterface

FILE: design/gcs_cfg_if.sv
// configuration write channel
interface gcs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gcs_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [gcs_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/gcs_cfg.sv
// configuration register file
module gcs_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  gcs_cfg_if.sink       cfg,
  output gcs_pkg::cfg_t cfg_o
);

  gcs_pkg::cfg_t regs_q, regs_d;

  assign cfg.ready = 1'b1;
  assign cfg_o     = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg.valid) begin
      unique case (gcs_pkg::cfg_idx_e'(cfg.index))
        gcs_pkg::CFG_COOL_TICKS: regs_d.cool_ticks = cfg.data[gcs_pkg::TIMER_BITS-1:0];
        gcs_pkg::CFG_DEAD_BAND:  regs_d.dead_band  = cfg.data[gcs_pkg::BAND_BITS-1:0];
        gcs_pkg::CFG_FAST_STEP:  regs_d.fast_step  = cfg.data[gcs_pkg::STEP_BITS-1:0];
        gcs_pkg::CFG_SLOW_STEP:  regs_d.slow_step  = cfg.data[gcs_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.cool_ticks <= gcs_pkg::COOL_TICKS_RST;
      regs_q.dead_band  <= gcs_pkg::DEAD_BAND_RST;
      regs_q.fast_step  <= gcs_pkg::FAST_STEP_RST;
      regs_q.slow_step  <= gcs_pkg::SLOW_STEP_RST;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

FILE: design/gcs_axis.sv
// stick axis scaling, centring and dead band
module gcs_axis #(
  parameter int SAMPLE_BITS = gcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]              raw_i,
  input  logic [gcs_pkg::BAND_BITS-1:0]       dead_band_i,
  output logic signed [gcs_pkg::AXIS_BITS-1:0] axis_o
);

  localparam int AB = gcs_pkg::AXIS_BITS;

  logic [AB-1:0] scaled;
  logic [AB-1:0] centred;
  logic [AB-1:0] mag;

  if (SAMPLE_BITS >= AB) begin : g_down
    assign scaled = raw_i[SAMPLE_BITS-1 -: AB];
  end else begin : g_up
    assign scaled = {raw_i, {(AB-SAMPLE_BITS){1'b0}}};
  end

  // subtracting midscale flips the top bit
  assign centred = {~scaled[AB-1], scaled[AB-2:0]};
  assign mag     = centred[AB-1] ? (~centred + AB'(1)) : centred;
  assign axis_o  = (mag < AB'(dead_band_i)) ? '0 : $signed(centred);

endmodule

FILE: design/gcs_core.sv
// command state: lockout timer, button effects and report status
module gcs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  gcs_pkg::cmd_t    cmd_i,
  input  gcs_pkg::cfg_t    cfg_i,
  output gcs_pkg::status_t status_o
);

  localparam int PB = gcs_pkg::POWER_BITS;
  localparam int MB = gcs_pkg::MODE_BITS;

  logic [gcs_pkg::TIMER_BITS-1:0] timer_q, timer_d;
  logic [PB-1:0]                  power_q, power_d;
  logic [MB-1:0]                  face_q, face_d;
  logic [MB-1:0]                  mode_q, mode_d;
  logic [MB-1:0]                  count_q, count_d;
  logic [MB-1:0]                  command_q, command_d;
  logic                           reload_q, reload_d;
  logic                           clear_q, clear_d;

  logic [gcs_pkg::STEP_BITS-1:0]  step;
  logic [PB:0]                    power_sum;
  logic [MB-1:0]                  command_now;
  logic                           unlocked;

  assign step      = cmd_i.fast_held ? cfg_i.fast_step : cfg_i.slow_step;
  assign power_sum = {1'b0, power_q} + {1'b0, step};
  assign unlocked  = timer_q >= cfg_i.cool_ticks;

  // shot command as seen by the report of an update
  always_comb begin
    command_now = command_q;
    if (command_q != gcs_pkg::CMD_FIRE) begin
      if (cmd_i.up_held && !cmd_i.down_held) begin
        command_now = gcs_pkg::CMD_UP;
      end else if (cmd_i.down_held && !cmd_i.up_held) begin
        command_now = gcs_pkg::CMD_DOWN;
      end else if (!cmd_i.up_held && !cmd_i.down_held) begin
        command_now = gcs_pkg::CMD_IDLE;
      end
    end
  end

  always_comb begin
    timer_d   = timer_q;
    power_d   = power_q;
    face_d    = face_q;
    mode_d    = mode_q;
    count_d   = count_q;
    command_d = command_q;
    reload_d  = reload_q;
    clear_d   = clear_q;
    unique case (gcs_pkg::action_e'(cmd_i.action))
      gcs_pkg::ACT_TICK: begin
        if (timer_q != gcs_pkg::TIMER_MAX) begin
          timer_d = timer_q + 1'b1;
        end
      end
      gcs_pkg::ACT_BUTTON: begin
        if (unlocked && (cmd_i.button != {gcs_pkg::BUTTON_BITS{1'b1}})) begin
          timer_d = '0;
          case (gcs_pkg::button_e'(cmd_i.button))
            gcs_pkg::BTN_POWER_UP: begin
              power_d = (power_sum > {1'b0, gcs_pkg::POWER_MAX}) ? gcs_pkg::POWER_MAX
                                                                 : power_sum[PB-1:0];
            end
            gcs_pkg::BTN_POWER_DOWN: begin
              power_d = (step > power_q) ? '0 : power_q - step;
            end
            gcs_pkg::BTN_FACE: begin
              face_d = (face_q == MB'(3)) ? MB'(1) : face_q + 1'b1;
            end
            gcs_pkg::BTN_RELOAD: begin
              reload_d = 1'b1;
              clear_d  = 1'b1;
            end
            gcs_pkg::BTN_MOVE_MODE: begin
              mode_d = (mode_q >= MB'(2)) ? '0 : mode_q + 1'b1;
            end
            gcs_pkg::BTN_SHOT_COUNT: begin
              count_d = (count_q >= MB'(2)) ? '0 : count_q + 1'b1;
            end
            gcs_pkg::BTN_FIRE: begin
              command_d = gcs_pkg::CMD_FIRE;
              clear_d   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      gcs_pkg::ACT_UPDATE: begin
        // pending clear lands after the report
        if (clear_q) begin
          reload_d  = 1'b0;
          command_d = gcs_pkg::CMD_IDLE;
          clear_d   = 1'b0;
        end else begin
          command_d = command_now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q   <= '0;
      power_q   <= '0;
      face_q    <= '0;
      mode_q    <= '0;
      count_q   <= '0;
      command_q <= gcs_pkg::CMD_IDLE;
      reload_q  <= 1'b0;
      clear_q   <= 1'b0;
    end else if (en_i) begin
      timer_q   <= timer_d;
      power_q   <= power_d;
      face_q    <= face_d;
      mode_q    <= mode_d;
      count_q   <= count_d;
      command_q <= command_d;
      reload_q  <= reload_d;
      clear_q   <= clear_d;
    end
  end

  assign status_o.stop_flag    = cmd_i.stop_level;
  assign status_o.move_mode    = mode_q;
  assign status_o.face_mode    = face_q;
  assign status_o.shot_command = command_now;
  assign status_o.shot_count   = count_q;
  assign status_o.power_level  = power_q;
  assign status_o.reload_flag  = reload_q;

endmodule

FILE: design/gamepad_command_state.sv
// top level: input register, command state, axis dead band and report register
// an update transaction passes the input register, then the report register, where its report is valid
// throughput: one transaction per cycle; an update waits only while the report
//   register is full and not being taken
// reset: config registers take their defaults, command state and valid flags clear; input and report data are not reset
module gamepad_command_state #(
  parameter int SAMPLE_BITS = gcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  gcs_cmd_if.sink  cmd,
  gcs_rpt_if.source rpt,
  gcs_cfg_if.sink  cfg
);

  localparam int AB = gcs_pkg::AXIS_BITS;

  gcs_pkg::cfg_t    cfg_regs;
  gcs_pkg::status_t status;

  logic                   in_valid_q, in_valid_d;
  gcs_pkg::cmd_t          in_cmd_q;
  logic [SAMPLE_BITS-1:0] in_x_q, in_y_q, in_turn_q;

  logic                   out_valid_q, out_valid_d;
  gcs_pkg::status_t       out_status_q;
  logic signed [AB-1:0]   out_x_q, out_y_q, out_turn_q;
  logic signed [AB-1:0]   axis_x, axis_y, axis_turn;

  logic in_take;
  logic is_update;
  logic out_free;
  logic advance;

  assign out_free  = !out_valid_q || rpt.ready;
  assign is_update = in_cmd_q.action == gcs_pkg::ACT_UPDATE;
  assign advance   = in_valid_q && (!is_update || out_free);
  assign cmd.ready = !in_valid_q || advance;
  assign in_take   = cmd.valid && cmd.ready;

  gcs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg),
    .cfg_o  (cfg_regs)
  );

  gcs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .cmd_i    (in_cmd_q),
    .cfg_i    (cfg_regs),
    .status_o (status)
  );

  gcs_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
    .raw_i       (in_x_q),
    .dead_band_i (cfg_regs.dead_band),
    .axis_o      (axis_x)
  );

  gcs_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
    .raw_i       (in_y_q),
    .dead_band_i (cfg_regs.dead_band),
    .axis_o      (axis_y)
  );

  gcs_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_turn (
    .raw_i       (in_turn_q),
    .dead_band_i (cfg_regs.dead_band),
    .axis_o      (axis_turn)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && is_update) begin
      out_valid_d = 1'b1;
    end else if (rpt.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q.action     <= cmd.action;
      in_cmd_q.button     <= cmd.button;
      in_cmd_q.fast_held  <= cmd.fast_held;
      in_cmd_q.up_held    <= cmd.up_held;
      in_cmd_q.down_held  <= cmd.down_held;
      in_cmd_q.stop_level <= cmd.stop_level;
      in_x_q              <= cmd.stick_x;
      in_y_q              <= cmd.stick_y;
      in_turn_q           <= cmd.stick_turn;
    end
    if (advance && is_update) begin
      out_status_q <= status;
      out_x_q      <= axis_x;
      out_y_q      <= axis_y;
      out_turn_q   <= axis_turn;
    end
  end

  assign rpt.valid        = out_valid_q;
  assign rpt.stop_flag    = out_status_q.stop_flag;
  assign rpt.move_mode    = out_status_q.move_mode;
  assign rpt.face_mode    = out_status_q.face_mode;
  assign rpt.shot_command = out_status_q.shot_command;
  assign rpt.shot_count   = out_status_q.shot_count;
  assign rpt.power_level  = out_status_q.power_level;
  assign rpt.reload_flag  = out_status_q.reload_flag;
  assign rpt.move_x       = out_x_q;
  assign rpt.move_y       = out_y_q;
  assign rpt.move_turn    = out_turn_q;

  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> out_valid_q && !rpt.ready
  ) else $error("input stage stalled with report register free");

  a_report_needs_update: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(advance && is_update) && !out_valid_q |=> !out_valid_q
  ) else $error("report raised without an update");

  a_power_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_status_q.power_level <= gcs_pkg::POWER_MAX
  ) else $error("reported power above limit");

  a_wrap_ranges: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q.move_mode != 2'd3) && (out_status_q.shot_count != 2'd3)
  ) else $error("mode or shot count out of range");

endmodule
